// ===== hw/rtl/fragment_reassembler_unit_macros.svh =====
// assertion macros for the fragment reassembler
`ifndef FRAGMENT_REASSEMBLER_UNIT_MACROS_SVH
`define FRAGMENT_REASSEMBLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define FR_ASSERT(lbl, prop, msg)
`define FR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/fr_pkg.sv =====
package fr_pkg;

  localparam int unsigned MaxMessageDef = 2048;
  localparam int unsigned ReadIdxW      = 11;
  localparam int unsigned MsgLenW       = 12;
  localparam logic [2:0]  HeaderBytes   = 3'd5;

  typedef enum logic [1:0] {
    OpFragByte = 2'd0,
    OpLink     = 2'd1,
    OpRead     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StPending  = 3'd0,
    StIgnored  = 3'd1,
    StMismatch = 3'd2,
    StOverrun  = 3'd3,
    StComplete = 3'd4,
    StRead     = 3'd5,
    StLink     = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [7:0]          data_byte;
    logic                frag_last;
    logic [ReadIdxW-1:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [MsgLenW-1:0] message_length;
    logic [7:0]         message_seq;
    logic [7:0]         read_data;
  } out_rsp_t;

endpackage

// ===== hw/rtl/fr_ram.sv =====
module fr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fragment_reassembler_unit.sv =====
// a request is taken into the input register, then its result into the result register
// throughput: one request per cycle unless the output stalls; each request is one state update
//   pass plus at most one access to the message store (a write or a registered read)
// reset: asynchronous, clears reassembly state and the last completed message;
//   the message store is not cleared and needs no clearing pass
`include "fragment_reassembler_unit_macros.svh"

module fragment_reassembler_unit import fr_pkg::*; #(
  parameter int unsigned MaxMessage = MaxMessageDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned LenW  = $clog2(MaxMessage + 1);
  localparam int unsigned AddrW = (MaxMessage > 1) ? $clog2(MaxMessage) : 1;
  localparam int unsigned CmpW  = (LenW > ReadIdxW) ? LenW : ReadIdxW;
  localparam logic [2:0]  HdrLast = HeaderBytes - 3'd1;

  // input register
  logic    in_vld_q;
  in_req_t in_req_q;

  // reassembly state
  logic [2:0]      hdr_cnt_q, hdr_cnt_d;
  logic [7:0]      frag_seq_q, frag_seq_d;
  logic [15:0]     frag_total_q, frag_total_d;
  logic [7:0]      off_lo_q, off_lo_d;
  logic            frag_acc_q, frag_acc_d;
  logic            in_prog_q, in_prog_d;
  logic [7:0]      exp_seq_q, exp_seq_d;
  logic [LenW-1:0] msg_total_q, msg_total_d;
  logic [LenW-1:0] recv_q, recv_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] done_len_q, done_len_d;
  logic [7:0]      done_seq_q, done_seq_d;

  // result register
  logic    out_vld_q;
  status_e out_status_q, status_d;
  logic    rd_hit_q, rd_hit_d;

  logic        adv, step;
  logic        wr_req, rd_req, finish;
  logic [15:0] offset;
  logic [7:0]  rdata;

  assign adv        = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign offset     = {in_req_q.data_byte, off_lo_q};

  always_comb begin
    hdr_cnt_d    = hdr_cnt_q;
    frag_seq_d   = frag_seq_q;
    frag_total_d = frag_total_q;
    off_lo_d     = off_lo_q;
    frag_acc_d   = frag_acc_q;
    in_prog_d    = in_prog_q;
    exp_seq_d    = exp_seq_q;
    msg_total_d  = msg_total_q;
    recv_d       = recv_q;
    pos_d        = pos_q;
    done_len_d   = done_len_q;
    done_seq_d   = done_seq_q;
    status_d     = StPending;
    rd_hit_d     = 1'b0;
    wr_req       = 1'b0;
    rd_req       = 1'b0;
    finish       = 1'b0;

    unique case (op_e'(in_req_q.operation))
      OpFragByte: begin
        if (hdr_cnt_q < HdrLast) begin
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          case (hdr_cnt_q)
            3'd0:    frag_seq_d = in_req_q.data_byte;
            3'd1:    frag_total_d[7:0] = in_req_q.data_byte;
            3'd2:    frag_total_d[15:8] = in_req_q.data_byte;
            default: off_lo_d = in_req_q.data_byte;
          endcase
          // short fragment
          if (in_req_q.frag_last) begin
            hdr_cnt_d  = '0;
            frag_acc_d = 1'b0;
            status_d   = StIgnored;
          end
        end else if (hdr_cnt_q == HdrLast) begin
          hdr_cnt_d = HeaderBytes;
          if ({1'b0, frag_total_q} > 17'(MaxMessage)) begin
            frag_acc_d = 1'b0;
            status_d   = StIgnored;
          end else begin
            if (offset == '0) begin
              exp_seq_d   = frag_seq_q;
              in_prog_d   = 1'b1;
              msg_total_d = LenW'(frag_total_q);
              recv_d      = '0;
            end
            if (!in_prog_d || frag_seq_q != exp_seq_d || offset != 16'(recv_d)) begin
              in_prog_d  = 1'b0;
              frag_acc_d = 1'b0;
              status_d   = StMismatch;
            end else begin
              frag_acc_d = 1'b1;
            end
          end
          pos_d  = recv_d;
          finish = in_req_q.frag_last;
        end else begin
          if (frag_acc_q) begin
            if (pos_q >= msg_total_q) begin
              in_prog_d  = 1'b0;
              frag_acc_d = 1'b0;
              status_d   = StOverrun;
            end else begin
              wr_req = 1'b1;
              pos_d  = pos_q + LenW'(1);
            end
          end
          finish = in_req_q.frag_last;
        end
      end
      OpLink: begin
        in_prog_d  = 1'b0;
        hdr_cnt_d  = '0;
        frag_acc_d = 1'b0;
        status_d   = StLink;
      end
      OpRead: begin
        rd_req   = 1'b1;
        rd_hit_d = CmpW'(in_req_q.read_index) < CmpW'(done_len_q);
        status_d = StRead;
      end
      default: begin
        status_d = StIgnored;
      end
    endcase

    // end of fragment
    if (finish) begin
      if (frag_acc_d) begin
        recv_d = pos_d;
        if (pos_d == msg_total_d) begin
          in_prog_d  = 1'b0;
          done_len_d = pos_d;
          done_seq_d = exp_seq_d;
          status_d   = StComplete;
        end
      end
      hdr_cnt_d  = '0;
      frag_acc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      hdr_cnt_q    <= '0;
      frag_seq_q   <= '0;
      frag_total_q <= '0;
      off_lo_q     <= '0;
      frag_acc_q   <= 1'b0;
      in_prog_q    <= 1'b0;
      exp_seq_q    <= '0;
      msg_total_q  <= '0;
      recv_q       <= '0;
      pos_q        <= '0;
      done_len_q   <= '0;
      done_seq_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      if (step) begin
        hdr_cnt_q    <= hdr_cnt_d;
        frag_seq_q   <= frag_seq_d;
        frag_total_q <= frag_total_d;
        off_lo_q     <= off_lo_d;
        frag_acc_q   <= frag_acc_d;
        in_prog_q    <= in_prog_d;
        exp_seq_q    <= exp_seq_d;
        msg_total_q  <= msg_total_d;
        recv_q       <= recv_d;
        pos_q        <= pos_d;
        done_len_q   <= done_len_d;
        done_seq_q   <= done_seq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_req_q <= in_req_i;
    end
    if (step) begin
      out_status_q <= status_d;
      rd_hit_q     <= rd_hit_d;
    end
  end

  fr_ram #(
    .Width (8),
    .Depth (MaxMessage)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (step && wr_req),
    .waddr_i (AddrW'(pos_q)),
    .wdata_i (in_req_q.data_byte),
    .re_i    (step && rd_req),
    .raddr_i (AddrW'(in_req_q.read_index)),
    .rdata_o (rdata)
  );

  assign out_valid_o              = out_vld_q;
  assign out_rsp_o.status         = out_status_q;
  assign out_rsp_o.message_length = MsgLenW'(done_len_q);
  assign out_rsp_o.message_seq    = done_seq_q;
  assign out_rsp_o.read_data      = rd_hit_q ? rdata : 8'd0;

  `FR_ASSERT(a_hdr_cnt_range, hdr_cnt_q <= HeaderBytes, "header count out of range")
  `FR_ASSERT(a_acc_in_prog, frag_acc_q |-> in_prog_q, "accepting without a message")
  `FR_ASSERT(a_pos_bounds, frag_acc_q |-> (pos_q <= msg_total_q && pos_q >= recv_q), "write position outside message")
  `FR_ASSERT(a_hit_read_only, out_vld_q && out_status_q != StRead |-> !rd_hit_q, "read hit on non-read result")
  `FR_ASSERT_NEXT(a_in_hold, in_vld_q && out_vld_q && out_stall_i, in_vld_q && $stable(in_req_q), "stalled request lost")

endmodule
